@@ rtl/tgc_pkg.sv @@
// Shared types and constants for the touch gesture classifier.
package tgc_pkg;

  // Fixed field and register widths
  localparam int ACT_W      = 2;
  localparam int GEST_W     = 3;
  localparam int PX_W       = 12;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Squared pixel limits and microsecond limits
  localparam int PX2_W = 2 * PX_W;
  localparam int THR_W = MS_W + 11;

  localparam logic [THR_W-1:0] US_PER_MS = THR_W'(1000);

  // Register reset values
  localparam logic            RST_ENABLED       = 1'b1;
  localparam logic [MS_W-1:0] RST_LONG_PRESS_MS = MS_W'(800);
  localparam logic [MS_W-1:0] RST_SWIPE_MAX_MS  = MS_W'(500);
  localparam logic [PX_W-1:0] RST_SWIPE_MIN_PX  = PX_W'(50);
  localparam logic [PX_W-1:0] RST_TAP_MAX_PX    = PX_W'(10);

  // Derived limits after reset
  localparam logic [THR_W-1:0] RST_LONG_THR  =
    THR_W'({11'd0, RST_LONG_PRESS_MS} * US_PER_MS);
  localparam logic [THR_W-1:0] RST_SWIPE_THR =
    THR_W'({11'd0, RST_SWIPE_MAX_MS} * US_PER_MS + US_PER_MS);
  localparam logic [PX2_W-1:0] RST_SWP2 =
    PX2_W'({12'd0, RST_SWIPE_MIN_PX} * {12'd0, RST_SWIPE_MIN_PX});
  localparam logic [PX2_W-1:0] RST_TAP2 =
    PX2_W'({12'd0, RST_TAP_MAX_PX} * {12'd0, RST_TAP_MAX_PX});

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED       = 3'd0,
    CFG_LONG_PRESS_MS = 3'd1,
    CFG_SWIPE_MAX_MS  = 3'd2,
    CFG_SWIPE_MIN_PX  = 3'd3,
    CFG_TAP_MAX_PX    = 3'd4
  } cfg_reg_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [GEST_W-1:0] {
    G_TAP   = 3'd0,
    G_LONG  = 3'd1,
    G_RIGHT = 3'd2,
    G_LEFT  = 3'd3,
    G_DOWN  = 3'd4,
    G_UP    = 3'd5
  } gesture_t;

  // One gesture moving between the parts
  typedef struct packed {
    logic     valid;
    gesture_t gesture;
  } gest_item_t;

endpackage

@@ rtl/tgc_front.sv @@
// Front part: accepts touch events, tracks the touch and classifies gestures.
module tgc_front #(
  parameter int COORD_BITS = 12,
  parameter int STAMP_BITS = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic                                full,
  input  logic [tgc_pkg::ACT_W-1:0]           action,
  input  logic [COORD_BITS-1:0]               pos_x,
  input  logic [COORD_BITS-1:0]               pos_y,
  input  logic [STAMP_BITS-1:0]               time_us,
  output tgc_pkg::gest_item_t                 push
);

  localparam int D2W  = 2 * COORD_BITS + 1;
  localparam int CMPW = (D2W > tgc_pkg::PX2_W) ? D2W : tgc_pkg::PX2_W;
  localparam int TW   = (STAMP_BITS > tgc_pkg::THR_W) ? STAMP_BITS : tgc_pkg::THR_W;

  // Configuration, held in derived form
  logic                            enabled;
  logic [tgc_pkg::THR_W-1:0]       long_thr;
  logic [tgc_pkg::THR_W-1:0]       swipe_thr;
  logic [tgc_pkg::PX2_W-1:0]       swp2;
  logic [tgc_pkg::PX2_W-1:0]       tap2;

  // Touch state
  logic                            armed;
  logic                            long_sent;
  logic [COORD_BITS-1:0]           start_x;
  logic [COORD_BITS-1:0]           start_y;
  logic [STAMP_BITS-1:0]           press_stamp;

  logic                            accept;
  logic signed [COORD_BITS:0]      dx;
  logic signed [COORD_BITS:0]      dy;
  logic [COORD_BITS-1:0]           ax;
  logic [COORD_BITS-1:0]           ay;
  logic [2*COORD_BITS-1:0]         sqx;
  logic [2*COORD_BITS-1:0]         sqy;
  logic [CMPW-1:0]                 d2;
  logic [STAMP_BITS-1:0]           elapsed;
  logic                            long_ok;
  logic                            swipe_time_ok;
  logic                            in_tap;
  logic                            far_enough;
  tgc_pkg::gesture_t               swipe_gest;
  tgc_pkg::gesture_t               gest;
  logic                            hit;
  logic [tgc_pkg::MS_W-1:0]        cfg_ms;
  logic [tgc_pkg::PX_W-1:0]        cfg_px;

  assign accept = in_valid && !full;
  assign cfg_ms = cfg_data[tgc_pkg::MS_W-1:0];
  assign cfg_px = cfg_data[tgc_pkg::PX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= tgc_pkg::RST_ENABLED;
      long_thr  <= tgc_pkg::RST_LONG_THR;
      swipe_thr <= tgc_pkg::RST_SWIPE_THR;
      swp2      <= tgc_pkg::RST_SWP2;
      tap2      <= tgc_pkg::RST_TAP2;
    end else if (cfg_we) begin
      unique case (tgc_pkg::cfg_reg_t'(cfg_index))
        tgc_pkg::CFG_ENABLED:       enabled <= cfg_data[0];
        tgc_pkg::CFG_LONG_PRESS_MS: begin
          long_thr <= tgc_pkg::THR_W'(tgc_pkg::THR_W'(cfg_ms) * tgc_pkg::US_PER_MS);
        end
        tgc_pkg::CFG_SWIPE_MAX_MS:  begin
          swipe_thr <= tgc_pkg::THR_W'(tgc_pkg::THR_W'(cfg_ms) * tgc_pkg::US_PER_MS
                                       + tgc_pkg::US_PER_MS);
        end
        tgc_pkg::CFG_SWIPE_MIN_PX:  begin
          swp2 <= tgc_pkg::PX2_W'(tgc_pkg::PX2_W'(cfg_px) * tgc_pkg::PX2_W'(cfg_px));
        end
        tgc_pkg::CFG_TAP_MAX_PX:    begin
          tap2 <= tgc_pkg::PX2_W'(tgc_pkg::PX2_W'(cfg_px) * tgc_pkg::PX2_W'(cfg_px));
        end
        default: ;
      endcase
    end
  end

  // Distance and hold time against the stored start of the touch
  always_comb begin
    dx = $signed({1'b0, pos_x}) - $signed({1'b0, start_x});
    dy = $signed({1'b0, pos_y}) - $signed({1'b0, start_y});
    ax = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    sqx = ax * ax;
    sqy = ay * ay;
    d2  = CMPW'(sqx) + CMPW'(sqy);
    elapsed       = time_us - press_stamp;
    long_ok       = TW'(elapsed) >= TW'(long_thr);
    swipe_time_ok = TW'(elapsed) <  TW'(swipe_thr);
    in_tap        = d2 <  CMPW'(tap2);
    far_enough    = d2 >= CMPW'(swp2);
    if (ax > ay) begin
      swipe_gest = dx[COORD_BITS] ? tgc_pkg::G_LEFT : tgc_pkg::G_RIGHT;
    end else begin
      swipe_gest = (!dy[COORD_BITS] && (dy != '0)) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
    end
  end

  always_comb begin
    hit  = 1'b0;
    gest = tgc_pkg::G_TAP;
    if (enabled && armed) begin
      unique case (tgc_pkg::action_t'(action))
        tgc_pkg::ACT_MOVE: begin
          if (long_ok && !long_sent && in_tap) begin
            hit  = 1'b1;
            gest = tgc_pkg::G_LONG;
          end
        end
        tgc_pkg::ACT_RELEASE: begin
          if (!long_sent) begin
            if (far_enough && swipe_time_ok) begin
              hit  = 1'b1;
              gest = swipe_gest;
            end else if (in_tap) begin
              hit  = 1'b1;
              gest = tgc_pkg::G_TAP;
            end
          end
        end
        default: ;
      endcase
    end
    push.valid   = accept && hit;
    push.gesture = gest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      long_sent <= 1'b0;
    end else if (accept && enabled) begin
      case (tgc_pkg::action_t'(action))
        tgc_pkg::ACT_PRESS: begin
          armed     <= 1'b1;
          long_sent <= 1'b0;
        end
        tgc_pkg::ACT_MOVE: begin
          if (hit) long_sent <= 1'b1;
        end
        tgc_pkg::ACT_RELEASE: armed <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && enabled && (tgc_pkg::action_t'(action) == tgc_pkg::ACT_PRESS)) begin
      start_x     <= pos_x;
      start_y     <= pos_y;
      press_stamp <= time_us;
    end
  end

endmodule

@@ rtl/tgc_queue.sv @@
// Two-entry gesture queue between the front and back parts.
module tgc_queue (
  input  logic                clk,
  input  logic                rst,
  input  tgc_pkg::gest_item_t push,
  input  logic                pop,
  output logic                full,
  output tgc_pkg::gest_item_t head
);

  tgc_pkg::gesture_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              do_push;
  logic              do_pop;

  assign full       = count == 2'd2;
  assign head.valid = count != 2'd0;
  assign head.gesture = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.gesture;
  end

endmodule

@@ rtl/tgc_back.sv @@
// Back part: output register that delivers gestures to the consumer.
module tgc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  tgc_pkg::gest_item_t           head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tgc_pkg::GEST_W-1:0]    gesture
);

  // Load when the register is empty or its transaction completes now
  assign pop = head.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) gesture <= head.gesture;
  end

endmodule

@@ rtl/touch_gesture_classifier.sv @@
// Top level of the touch gesture classifier: front, queue and back parts.
//
// Touch events (press, move, release) with a point and a microsecond stamp
// enter on the input channel; a transaction completes at a rising edge with
// in_valid high and in_stall low. Each event is classified combinationally
// in the cycle it is accepted, so one event per clock is taken back to back
// while in_stall is low; the coordinate squares and the stamp subtract are
// combinational. A gesture (0 tap, 1 long press, 2 right, 3 left, 4 down,
// 5 up) is written into the queue and then into the output register that
// drives out_valid/gesture. A two-entry queue and the output register part
// the sides, so in_stall rises only when both queue slots hold undelivered
// gestures. The user writes registers through cfg_we/cfg_index/cfg_data only
// while idle, not enforced by the block itself: 0 enabled, 1 long_press_ms,
// 2 swipe_max_ms, 3 swipe_min_px, 4 tap_max_px; other indexes are dropped.
module touch_gesture_classifier #(
  parameter int COORD_BITS = 12,
  parameter int STAMP_BITS = 40
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tgc_pkg::ACT_W-1:0]        action,
  input  logic [COORD_BITS-1:0]            pos_x,
  input  logic [COORD_BITS-1:0]            pos_y,
  input  logic [STAMP_BITS-1:0]            time_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tgc_pkg::GEST_W-1:0]       gesture
);

  tgc_pkg::gest_item_t push;
  tgc_pkg::gest_item_t head;
  logic                full;
  logic                pop;

  // Hold the input while the queue has no free slot
  assign in_stall = full;

  // Front: configuration, touch state and classification
  tgc_front #(
    .COORD_BITS (COORD_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .full      (full),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .time_us   (time_us),
    .push      (push)
  );

  // Queue: buffer gestures so that a stalled consumer does not block events until both slots are full
  tgc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  // Back: advance the head gesture into the output register
  tgc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gesture   (gesture)
  );

endmodule
